>>> design/crb_pkg.sv
// Shared types and constants for the chunk reassembly buffer.
`default_nettype none

package crb_pkg;

   // Operation codes carried on req_operation
   localparam logic [1:0] OP_CHUNK = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Fixed field widths of the item ports
   localparam int OP_W        = 2;
   localparam int INDEX_W     = 16;
   localparam int TOTAL_W     = 16;
   localparam int LEN_W       = 5;
   localparam int WORD_W      = 64;
   localparam int READ_ADDR_W = 14;
   localparam int COUNT_OUT_W = 11;
   localparam int END_OUT_W   = 15;
   localparam int BYTE_W      = 8;

   // Width of the arrival epoch tag
   localparam int EPOCH_W = 8;

   // Byte write request into the image store
   typedef struct packed {
      logic              wr_en;
      logic [BYTE_W-1:0] wr_data;
   } crb_wr_type;

endpackage

`default_nettype wire

>>> design/crb_image.sv
// Byte-wide image store with one write port and one registered read port.
`default_nettype none

module crb_image
   import crb_pkg::*;
#(
   parameter int BUFFER_BYTES = 16384,
   parameter int AW           = $clog2(BUFFER_BYTES)
) (
   input  wire logic                   clock,
   input  wire crb_wr_type             wr,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [READ_ADDR_W-1:0] rd_addr,
   output logic      [BYTE_W-1:0]      rd_data
);

   localparam int RW = READ_ADDR_W + 4;

   logic [BYTE_W-1:0] image_mem [BUFFER_BYTES];
   logic [BYTE_W-1:0] rd_word_ff;
   logic              rd_hit_ff;
   logic              rd_hit;
   logic [AW-1:0]     rd_idx;

   // Flag addresses past the end of the buffer
   assign rd_hit = (RW'(rd_addr) < RW'(BUFFER_BYTES));
   assign rd_idx = AW'(rd_addr);

   // Write one byte, read one byte each cycle
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         image_mem[wr_addr] <= wr.wr_data;
      end
      rd_word_ff <= image_mem[rd_idx];
      rd_hit_ff  <= rd_hit;
   end

   // Out-of-range reads return zero
   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

>>> design/chunk_reassembly_buffer_unit.sv
// Top level of the chunk reassembly buffer: sequencer, arrival tags and status.
`default_nettype none

// One item at a time. A store-chunk item passes from acceptance to its status
// through decode, range check, arrival lookup, then one byte per cycle into the
// byte-wide image store (a rejected chunk skips lookup and store); clear, read
// and unused codes pass through decode only. Arrival marks are kept as epoch tags in a
// MAX_CHUNKS-entry memory; a clear or a change of total bumps the epoch, and
// when the 8-bit epoch wraps (every 255th such event) a sweep rewrites all
// tags before the item finishes. After reset the same sweep runs before
// req_ready rises.
// Stored image bytes are not cleared; only written bytes read back meaningfully.
module chunk_reassembly_buffer_unit
   import crb_pkg::*;
#(
   parameter int BUFFER_BYTES = 16384,
   parameter int CHUNK_BYTES  = 24,
   parameter int MAX_CHUNKS   = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OP_W-1:0]        req_operation,
   input  wire logic [INDEX_W-1:0]     req_chunk_index,
   input  wire logic [TOTAL_W-1:0]     req_chunk_total,
   input  wire logic [LEN_W-1:0]       req_data_length,
   input  wire logic [WORD_W-1:0]      req_payload_low,
   input  wire logic [WORD_W-1:0]      req_payload_mid,
   input  wire logic [WORD_W-1:0]      req_payload_high,
   input  wire logic [READ_ADDR_W-1:0] req_read_address,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_accepted,
   output logic                        rsp_first_arrival,
   output logic [COUNT_OUT_W-1:0]      rsp_chunks_received,
   output logic [TOTAL_W-1:0]          rsp_expected_total,
   output logic [END_OUT_W-1:0]        rsp_image_end,
   output logic                        rsp_complete,
   output logic [BYTE_W-1:0]           rsp_read_byte
);

   localparam int CIW  = $clog2(MAX_CHUNKS);
   localparam int CNTW = $clog2(MAX_CHUNKS + 1);
   localparam int AW   = $clog2(BUFFER_BYTES);
   localparam int OW   = $clog2(MAX_CHUNKS * CHUNK_BYTES + BUFFER_BYTES + 1);
   localparam int PW   = 3 * WORD_W;

   // Sequencer states
   localparam logic [2:0] S_SWEEP  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_DECODE = 3'd2;
   localparam logic [2:0] S_RANGE  = 3'd3;
   localparam logic [2:0] S_LOOKUP = 3'd4;
   localparam logic [2:0] S_WRITE  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // Control state
   logic [2:0]         state_ff, state_in;
   logic [2:0]         ret_ff, ret_in;
   logic [CIW-1:0]     sweep_ff, sweep_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [CNTW-1:0]    count_ff, count_in;
   logic [OW-1:0]      end_ff, end_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Latched item and work registers
   logic [OP_W-1:0]        op_ff, op_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;
   logic [TOTAL_W-1:0]     ctot_ff, ctot_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [PW-1:0]          pay_ff, pay_in;
   logic [READ_ADDR_W-1:0] raddr_ff, raddr_in;
   logic [OW-1:0]          base_ff, base_in;
   logic [OW-1:0]          waddr_ff, waddr_in;
   logic [LEN_W-1:0]       rem_ff, rem_in;
   logic                   acc_ff, acc_in;
   logic                   fresh_ff, fresh_in;

   // Result register
   logic                   rsp_acc_ff, rsp_acc_in;
   logic                   rsp_fresh_ff, rsp_fresh_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [END_OUT_W-1:0]   rsp_end_ff, rsp_end_in;
   logic                   rsp_cmpl_ff, rsp_cmpl_in;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;

   // Arrival tag memory
   logic [EPOCH_W-1:0] tag_mem [MAX_CHUNKS];
   logic [EPOCH_W-1:0] tag_q_ff;
   logic               tag_we;
   logic [CIW-1:0]     tag_waddr;
   logic [EPOCH_W-1:0] tag_wdata;
   logic [CIW-1:0]     tag_raddr;

   // Image store port
   crb_wr_type         img_wr;
   logic [BYTE_W-1:0]  img_rd_data;

   logic [OW-1:0]      stop_w;
   logic [EPOCH_W-1:0] epoch_nx;
   logic               chunk_ok;

   assign stop_w    = base_ff + OW'(len_ff);
   assign epoch_nx  = epoch_ff + EPOCH_W'(1);
   assign tag_raddr = idx_ff[CIW-1:0];
   assign chunk_ok  = (idx_ff < INDEX_W'(MAX_CHUNKS)) &&
                      (len_ff <= LEN_W'(CHUNK_BYTES)) &&
                      (stop_w <= OW'(BUFFER_BYTES));

   // Next-state logic of the sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      sweep_in     = sweep_ff;
      epoch_in     = epoch_ff;
      count_in     = count_ff;
      end_in       = end_ff;
      total_in     = total_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      ctot_in      = ctot_ff;
      len_in       = len_ff;
      pay_in       = pay_ff;
      raddr_in     = raddr_ff;
      base_in      = base_ff;
      waddr_in     = waddr_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_fresh_in = rsp_fresh_ff;
      rsp_count_in = rsp_count_ff;
      rsp_total_in = rsp_total_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_cmpl_in  = rsp_cmpl_ff;
      rsp_byte_in  = rsp_byte_ff;
      tag_we       = 1'b0;
      tag_waddr    = tag_raddr;
      tag_wdata    = epoch_ff;
      img_wr       = '0;

      case (state_ff)
         // Rewrite every arrival tag to zero
         S_SWEEP: begin
            tag_we    = 1'b1;
            tag_waddr = sweep_ff;
            tag_wdata = '0;
            sweep_in  = sweep_ff + CIW'(1);
            if (sweep_ff == CIW'(MAX_CHUNKS - 1)) begin
               state_in = ret_ff;
            end
         end

         // Take an item
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               idx_in   = req_chunk_index;
               ctot_in  = req_chunk_total;
               len_in   = req_data_length;
               pay_in   = {req_payload_high, req_payload_mid, req_payload_low};
               raddr_in = req_read_address;
               state_in = S_DECODE;
            end
         end

         // Apply clears and total changes, form the base offset
         S_DECODE: begin
            acc_in   = 1'b0;
            fresh_in = 1'b0;
            base_in  = OW'(idx_ff[CIW-1:0]) * OW'(CHUNK_BYTES);
            state_in = S_DONE;
            case (op_ff)
               OP_CHUNK: begin
                  state_in = S_RANGE;
                  if (ctot_ff != total_ff) begin
                     count_in = '0;
                     end_in   = '0;
                     total_in = ctot_ff;
                     epoch_in = epoch_nx;
                     if (epoch_nx == '0) begin
                        epoch_in = EPOCH_W'(1);
                        sweep_in = '0;
                        ret_in   = S_RANGE;
                        state_in = S_SWEEP;
                     end
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  end_in   = '0;
                  total_in = '0;
                  epoch_in = epoch_nx;
                  if (epoch_nx == '0) begin
                     epoch_in = EPOCH_W'(1);
                     sweep_in = '0;
                     ret_in   = S_DONE;
                     state_in = S_SWEEP;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // Reject bad index, length or overrun; tag read goes out here
         S_RANGE: begin
            state_in = chunk_ok ? S_LOOKUP : S_DONE;
         end

         // Mark arrival, count new indices, raise the end offset
         S_LOOKUP: begin
            tag_we   = 1'b1;
            acc_in   = 1'b1;
            if (tag_q_ff != epoch_ff) begin
               fresh_in = 1'b1;
               count_in = count_ff + CNTW'(1);
            end
            if (stop_w > end_ff) begin
               end_in = stop_w;
            end
            waddr_in = base_ff;
            rem_in   = len_ff;
            state_in = (len_ff == '0) ? S_DONE : S_WRITE;
         end

         // Store one payload byte per cycle
         S_WRITE: begin
            img_wr.wr_en   = 1'b1;
            img_wr.wr_data = pay_ff[BYTE_W-1:0];
            pay_in         = pay_ff >> BYTE_W;
            waddr_in       = waddr_ff + OW'(1);
            rem_in         = rem_ff - LEN_W'(1);
            if (rem_ff == LEN_W'(1)) begin
               state_in = S_DONE;
            end
         end

         // Load the result register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_fresh_in = fresh_ff;
               rsp_count_in = COUNT_OUT_W'(count_ff);
               rsp_total_in = total_ff;
               rsp_end_in   = END_OUT_W'(end_ff);
               rsp_cmpl_in  = (total_ff != '0) && (TOTAL_W'(count_ff) == total_ff);
               rsp_byte_in  = (op_ff == OP_READ) ? img_rd_data : '0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         ret_ff       <= S_IDLE;
         sweep_ff     <= '0;
         epoch_ff     <= EPOCH_W'(1);
         count_ff     <= '0;
         end_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         end_ff       <= end_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      ctot_ff      <= ctot_in;
      len_ff       <= len_in;
      pay_ff       <= pay_in;
      raddr_ff     <= raddr_in;
      base_ff      <= base_in;
      waddr_ff     <= waddr_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      fresh_ff     <= fresh_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_count_ff <= rsp_count_in;
      rsp_total_ff <= rsp_total_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_cmpl_ff  <= rsp_cmpl_in;
      rsp_byte_ff  <= rsp_byte_in;
   end

   // Arrival tag memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_q_ff <= tag_mem[tag_raddr];
   end

   crb_image #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .AW           (AW)
   ) u_image (
      .clock   (clock),
      .wr      (img_wr),
      .wr_addr (waddr_ff[AW-1:0]),
      .rd_addr (raddr_ff),
      .rd_data (img_rd_data)
   );

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_first_arrival   = rsp_fresh_ff;
   assign rsp_chunks_received = rsp_count_ff;
   assign rsp_expected_total  = rsp_total_ff;
   assign rsp_image_end       = rsp_end_ff;
   assign rsp_complete        = rsp_cmpl_ff;
   assign rsp_read_byte       = rsp_byte_ff;

   // Byte writes stay inside the buffer
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (waddr_ff < OW'(BUFFER_BYTES)))
      else $error("image write past end of buffer");

   // Distinct-index count never exceeds the number of indices
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_CHUNKS))
      else $error("received count out of range");

   // End offset never passes the buffer size
   a_end_bound: assert property (@(posedge clock) disable iff (reset)
      end_ff <= OW'(BUFFER_BYTES))
      else $error("end offset past buffer");

   // A new arrival bumps the count by exactly one
   a_fresh_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP && tag_q_ff != epoch_ff) |=>
      (count_ff == CNTW'($past(count_ff) + CNTW'(1))))
      else $error("new arrival not counted");

   // Live epoch never matches the swept tag value
   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      epoch_ff != '0)
      else $error("epoch reached zero");

endmodule

`default_nettype wire
